@@ hdl/etsd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package etsd_pkg;

   // Frame geometry
   localparam int DataBits  = 8;
   localparam int FrameDone = DataBits + 1;
   localparam int GapLimit  = DataBits + 3;
   localparam int PosMax    = 15;
   localparam int SlotsTop  = (DataBits < 8) ? DataBits : 8;

   // Field widths
   localparam int TsWidth   = 64;
   localparam int BtWidth   = 27;
   localparam int PosWidth  = 5;
   localparam int RemWidth  = 32;
   localparam int ByteWidth = 8;

   localparam logic [BtWidth-1:0] BitTimeReset = BtWidth'(104166);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

@@ hdl/edge_timestamp_serial_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  req_edge_level, req_timestamp_ns
// rsp_      out        rsp_valid / rsp_stall  rsp_received_byte
// csr_      in         csr_wr_en              csr_bit_time_ns
//
// A request steps through check, divide and finish; the divide peels off n bit times,
// n being the gap rounded to bit times (at most DataBits + 3); a restarting edge skips it.
// The rounding divide is one shared subtract/compare unit, one bit slot per cycle.
// Synchronous active-high reset clears timing state, bit position and byte.
// A result waits in the rsp_ register; a stalled result holds the next request
// in its final cycle only if that request also completes a character.

module edge_timestamp_serial_decoder
   import etsd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_edge_level,
   input  wire logic [TsWidth-1:0]   req_timestamp_ns,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [ByteWidth-1:0]      rsp_received_byte,
   input  wire logic                 csr_wr_en,
   input  wire logic [BtWidth-1:0]   csr_bit_time_ns
);

   localparam logic signed [PosWidth-1:0] PosStart = -PosWidth'(1);
   localparam logic signed [PosWidth-1:0] PosDone  = PosWidth'(FrameDone);
   localparam logic signed [PosWidth-1:0] PosSat   = PosWidth'(PosMax);
   localparam logic signed [PosWidth-1:0] PosSlots = PosWidth'(SlotsTop);

   state_type                   state_ff, state_in;
   logic [BtWidth-1:0]          bit_time_ff;
   logic [TsWidth-1:0]          last_time_ff, last_time_in;
   logic [TsWidth-1:0]          gap_ff, gap_in;
   logic [RemWidth-1:0]         rem_ff, rem_in;
   logic signed [PosWidth-1:0]  pos_ff, pos_in;
   logic                        held_ff, held_in;
   logic                        level_ff, level_in;
   logic [ByteWidth-1:0]        byte_ff, byte_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [ByteWidth-1:0]        rsp_byte_ff, rsp_byte_in;

   logic [BtWidth-1:0]          bt_eff;
   logic [RemWidth-1:0]         bt_wide;
   logic [RemWidth-1:0]         gap_max;
   logic                        long_gap;
   logic                        rem_ge;
   logic                        req_take;
   logic                        rsp_free;
   logic [2:0]                  slot_bit;

   // Treat a zero bit time as one nanosecond
   assign bt_eff   = (bit_time_ff == '0) ? BtWidth'(1) : bit_time_ff;
   assign bt_wide  = RemWidth'(bt_eff);
   assign gap_max  = bt_wide * RemWidth'(GapLimit);
   assign long_gap = (gap_ff[TsWidth-1:RemWidth] != '0) || (gap_ff[RemWidth-1:0] > gap_max);
   assign rem_ge   = (rem_ff >= bt_wide);
   assign req_take = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign slot_bit = 3'(7) - pos_ff[2:0];

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_received_byte = rsp_byte_ff;

   // Sequence one edge through check, divide and finish
   always_comb begin
      state_in     = state_ff;
      last_time_in = last_time_ff;
      gap_in       = gap_ff;
      rem_in       = rem_ff;
      pos_in       = pos_ff;
      held_in      = held_ff;
      level_in     = level_ff;
      byte_in      = byte_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_byte_in  = rsp_byte_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               gap_in       = req_timestamp_ns - last_time_ff;
               last_time_in = req_timestamp_ns;
               level_in     = req_edge_level;
               state_in     = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // Restart on a long gap or after a complete frame
            if (pos_ff == PosDone || long_gap) begin
               pos_in   = PosStart;
               state_in = ST_FINISH;
            end else begin
               rem_in   = gap_ff[RemWidth-1:0] + RemWidth'(bt_eff >> 1);
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            // Peel off one bit time per cycle, filling the current slot if it is a data bit
            if (rem_ge) begin
               rem_in = rem_ff - bt_wide;
               if (pos_ff >= 0 && pos_ff < PosSlots) begin
                  byte_in[slot_bit] = held_ff;
               end
               if (pos_ff != PosSat) begin
                  pos_in = pos_ff + PosWidth'(1);
               end
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (pos_ff != PosDone) begin
               held_in  = level_ff;
               state_in = ST_IDLE;
            end else if (rsp_free) begin
               held_in      = level_ff;
               rsp_valid_in = 1'b1;
               rsp_byte_in  = byte_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bit_time_ff  <= BitTimeReset;
         last_time_ff <= '0;
         pos_ff       <= '0;
         held_ff      <= 1'b0;
         byte_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_time_ff <= last_time_in;
         pos_ff       <= pos_in;
         held_ff      <= held_in;
         byte_ff      <= byte_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            bit_time_ff <= csr_bit_time_ns;
         end
      end
   end

   // Working registers, no reset needed
   always_ff @(posedge clock) begin
      gap_ff      <= gap_in;
      rem_ff      <= rem_in;
      level_ff    <= level_in;
      rsp_byte_ff <= rsp_byte_in;
   end

endmodule

`default_nettype wire
